// ===== hw/rtl/bwl_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded-wait lock arbiter package
// Shared types and constants for the front end, command queue and back end.
// ----------------------------------------------------------------------------
package bwl_pkg;

  localparam int SLOT_W = 4;
  localparam int MODE_W = 2;

  // Operation codes as they arrive on the mode field.
  localparam logic [MODE_W-1:0] MODE_ASSIGN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENTER  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEAVE  = 2'd2;

  // Command queue geometry.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  // Classified operation after range checking.
  typedef enum logic [1:0] {
    OP_ASSIGN,
    OP_ENTER,
    OP_LEAVE,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic              grant_valid;
    logic [SLOT_W-1:0] granted_slot;
    logic              lock_free;
    logic [SLOT_W-1:0] assigned_slot;
    logic              status;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  typedef struct packed {
    logic scanning;
    logic lock_held;
  } back_sts_t;

endpackage

// ===== hw/rtl/bounded_wait_lock_arbiter.sv =====
// ----------------------------------------------------------------------------
// Bounded-wait lock arbiter
// Hardware mutex with slot assignment and round-robin handoff on release.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake        Fields
//  -------   --------------   -----------------------------------------------
//  request   push / full      mode, slot
//  result    empty / pop      grant_valid, granted_slot, lock_free,
//                             assigned_slot, status
//
// Assign, enter and ignored operations are written into the command queue at
// the push transfer and then loaded into the result register, from which the
// result transfers out on a pop.
// A leave first has the back end scan the waiting marks, inspecting from one
// to SLOTS-1 marks; the scan reads one mark per cycle.
// Reset clears the lock, all waiting marks, the slot counter, the command
// queue and the result valid flag.
// The command queue keeps taking requests while a result waits for its pop.
//
module bounded_wait_lock_arbiter #(
  parameter int SLOTS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [bwl_pkg::MODE_W-1:0]   mode,
  input  logic [bwl_pkg::SLOT_W-1:0]   slot,
  output logic                         empty,
  input  logic                         pop,
  output logic                         grant_valid,
  output logic [bwl_pkg::SLOT_W-1:0]   granted_slot,
  output logic                         lock_free,
  output logic [bwl_pkg::SLOT_W-1:0]   assigned_slot,
  output logic                         status
);

  bwl_pkg::cmd_t               front_cmd;
  bwl_pkg::cmd_t               q_cmd;
  logic                        q_empty;
  logic [bwl_pkg::CMDQ_CW-1:0] q_count;
  logic                        q_take;
  bwl_pkg::result_t            res;
  logic                        res_valid;
  bwl_pkg::back_sts_t          back_sts;

  // The front end classifies each request so the back end sees only
  // in-range slot operations or an explicit ignore.
  bwl_front #(.SLOTS(SLOTS)) u_front (
    .mode (mode),
    .slot (slot),
    .cmd  (front_cmd)
  );

  // The command queue lets requests transfer in while the back end scans.
  bwl_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_cmd),
    .empty   (q_empty),
    .count   (q_count)
  );

  // The back end owns the lock state and the single result register.
  bwl_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_take  (q_take),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop),
    .sts       (back_sts)
  );

  assign empty         = !res_valid;
  assign grant_valid   = res.grant_valid;
  assign granted_slot  = res.granted_slot;
  assign lock_free     = res.lock_free;
  assign assigned_slot = res.assigned_slot;
  assign status        = res.status;

  // A scan only starts once the result register is free, so no result
  // can be waiting while the back end walks the marks.
  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    back_sts.scanning |-> empty)
    else $error("result pending during leave scan");

  // While a result waits, the lock state cannot move, so the reported
  // lock state must match the live one.
  a_lock_matches: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (lock_free == !back_sts.lock_held))
    else $error("reported lock state differs from held state");

  // The back end takes no command while scanning, so the queue cannot drain.
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    back_sts.scanning |=> (q_count >= $past(q_count)))
    else $error("command queue drained during leave scan");

endmodule

// ===== hw/rtl/bwl_front.sv =====
// ----------------------------------------------------------------------------
// Bounded-wait lock arbiter front end
// Decodes the mode field and range-checks the slot into a queued command.
// ----------------------------------------------------------------------------
module bwl_front #(
  parameter int SLOTS = 10
) (
  input  logic [bwl_pkg::MODE_W-1:0] mode,
  input  logic [bwl_pkg::SLOT_W-1:0] slot,
  output bwl_pkg::cmd_t              cmd
);

  logic in_range;

  assign in_range = (32'(slot) < SLOTS);

  always_comb begin
    cmd.slot = slot;
    unique case (mode)
      bwl_pkg::MODE_ASSIGN: cmd.op = bwl_pkg::OP_ASSIGN;
      bwl_pkg::MODE_ENTER:  cmd.op = in_range ? bwl_pkg::OP_ENTER : bwl_pkg::OP_IGNORE;
      bwl_pkg::MODE_LEAVE:  cmd.op = in_range ? bwl_pkg::OP_LEAVE : bwl_pkg::OP_IGNORE;
      default:              cmd.op = bwl_pkg::OP_IGNORE;
    endcase
  end

endmodule

// ===== hw/rtl/bwl_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Bounded-wait lock arbiter command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bwl_cmd_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  bwl_pkg::cmd_t                wr_data,
  output logic                         full,
  input  logic                         rd_en,
  output bwl_pkg::cmd_t                rd_data,
  output logic                         empty,
  output logic [bwl_pkg::CMDQ_CW-1:0]  count
);

  bwl_pkg::cmd_t                entries [bwl_pkg::CMDQ_DEPTH];
  logic [bwl_pkg::CMDQ_AW-1:0]  wr_ptr;
  logic [bwl_pkg::CMDQ_AW-1:0]  rd_ptr;
  logic                         do_wr;
  logic                         do_rd;

  assign full    = (count == bwl_pkg::CMDQ_CW'(bwl_pkg::CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  function automatic logic [bwl_pkg::CMDQ_AW-1:0] ptr_inc(
    input logic [bwl_pkg::CMDQ_AW-1:0] p
  );
    ptr_inc = (p == bwl_pkg::CMDQ_AW'(bwl_pkg::CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= ptr_inc(wr_ptr);
      if (do_rd) rd_ptr <= ptr_inc(rd_ptr);
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

endmodule

// ===== hw/rtl/bwl_back.sv =====
// ----------------------------------------------------------------------------
// Bounded-wait lock arbiter back end
// Holds the lock state, runs operations and scans waiting marks on leave.
// ----------------------------------------------------------------------------
module bwl_back #(
  parameter int SLOTS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  bwl_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output bwl_pkg::result_t   res,
  output logic               res_valid,
  input  logic               res_pop,
  output bwl_pkg::back_sts_t sts
);

  localparam int SIDX_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  bwl_pkg::back_state_t state, state_next;
  logic [SLOTS-1:0]     marks, marks_next;
  logic                 lock_held, lock_held_next;
  logic [CNT_W-1:0]     next_free, next_free_next;
  logic [SIDX_W-1:0]    cand, cand_next;
  logic [SIDX_W-1:0]    remain, remain_next;
  bwl_pkg::result_t     res_next;
  logic                 res_load;
  logic [SIDX_W-1:0]    slot_idx;

  function automatic logic [SIDX_W-1:0] wrap_inc(input logic [SIDX_W-1:0] i);
    wrap_inc = (i == SIDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  assign slot_idx = SIDX_W'(cmd.slot);
  assign cmd_take = (state == bwl_pkg::ST_IDLE) && cmd_valid && (!res_valid || res_pop);
  assign sts.scanning  = (state == bwl_pkg::ST_SCAN);
  assign sts.lock_held = lock_held;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bwl_pkg::ST_IDLE: begin
        if (cmd_take && cmd.op == bwl_pkg::OP_LEAVE) state_next = bwl_pkg::ST_SCAN;
      end
      bwl_pkg::ST_SCAN: begin
        if (marks[cand] || remain == SIDX_W'(1)) state_next = bwl_pkg::ST_IDLE;
      end
      default: state_next = bwl_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and result formation.
  always_comb begin
    marks_next     = marks;
    lock_held_next = lock_held;
    next_free_next = next_free;
    cand_next      = cand;
    remain_next    = remain;
    res_next       = '0;
    res_next.lock_free = !lock_held;
    res_load       = 1'b0;
    unique case (state)
      bwl_pkg::ST_IDLE: begin
        if (cmd_take) begin
          unique case (cmd.op)
            bwl_pkg::OP_ASSIGN: begin
              res_load = 1'b1;
              if (next_free < CNT_W'(SLOTS)) begin
                res_next.assigned_slot = bwl_pkg::SLOT_W'(next_free);
                next_free_next = next_free + 1'b1;
              end else begin
                res_next.status = 1'b1;
              end
            end
            bwl_pkg::OP_ENTER: begin
              res_load = 1'b1;
              res_next.lock_free = 1'b0;
              if (!lock_held) begin
                lock_held_next           = 1'b1;
                marks_next[slot_idx]     = 1'b0;
                res_next.grant_valid     = 1'b1;
                res_next.granted_slot    = cmd.slot;
              end else begin
                marks_next[slot_idx]     = 1'b1;
              end
            end
            bwl_pkg::OP_LEAVE: begin
              cand_next   = wrap_inc(slot_idx);
              remain_next = SIDX_W'(SLOTS - 1);
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      bwl_pkg::ST_SCAN: begin
        if (marks[cand]) begin
          res_load              = 1'b1;
          marks_next[cand]      = 1'b0;
          lock_held_next        = 1'b1;
          res_next.grant_valid  = 1'b1;
          res_next.granted_slot = bwl_pkg::SLOT_W'(cand);
          res_next.lock_free    = 1'b0;
        end else if (remain == SIDX_W'(1)) begin
          res_load           = 1'b1;
          lock_held_next     = 1'b0;
          res_next.lock_free = 1'b1;
        end else begin
          cand_next   = wrap_inc(cand);
          remain_next = remain - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bwl_pkg::ST_IDLE;
      marks     <= '0;
      lock_held <= 1'b0;
      next_free <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      marks     <= marks_next;
      lock_held <= lock_held_next;
      next_free <= next_free_next;
      if (res_load) res_valid <= 1'b1;
      else if (res_pop) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cand   <= cand_next;
    remain <= remain_next;
    if (res_load) res <= res_next;
  end

endmodule
